>>> rtl/core/nmmd_pkg.sv
// Package for the new-moon minimum detector: shared constants, state types
// and the CORDIC angle table. No dependencies.
package nmmd_pkg;

  localparam int FRAC_BITS_DEF   = 30;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int IN_W    = 32;
  localparam int MAG_W   = 32;
  localparam int PHASE_W = 31;
  localparam int WIN_W   = 16;
  localparam int IDX_W   = 16;
  localparam int CFG_W   = 32;

  localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI = 31'sd843314857;
  localparam int CORDIC_STEPS = 30;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW    = 2'd0;
  localparam logic [1:0] CFG_RISE      = 2'd1;
  localparam logic [1:0] CFG_NEAR_ZERO = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd41760;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_SQ, ST_ACC, ST_SQRT, ST_DIVGO, ST_DIV,
    ST_SUM, ST_MSQ, ST_MACC, ST_MSQRT, ST_PH, ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    CD_IDLE, CD_NORM, CD_ITER, CD_FIN
  } cordic_state_t;

  // atan(2^-i) in Q2.29
  function automatic logic signed [31:0] cordic_angle(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:    a = 32'sd421657428;
      5'd1:    a = 32'sd248918915;
      5'd2:    a = 32'sd131521918;
      5'd3:    a = 32'sd66762579;
      5'd4:    a = 32'sd33510843;
      5'd5:    a = 32'sd16771758;
      5'd6:    a = 32'sd8387925;
      5'd7:    a = 32'sd4194219;
      5'd8:    a = 32'sd2097141;
      5'd9:    a = 32'sd1048575;
      5'd10:   a = 32'sd524288;
      default: a = 32'sd1 <<< (5'd29 - i);
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/nmmd_if.sv
// Stream interfaces for sample and result beats.
// Depends on nmmd_pkg.
interface nmmd_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [nmmd_pkg::IN_W-1:0] moon_x;
  logic signed [nmmd_pkg::IN_W-1:0] moon_y;
  logic signed [nmmd_pkg::IN_W-1:0] moon_z;
  logic signed [nmmd_pkg::IN_W-1:0] sun_x;
  logic signed [nmmd_pkg::IN_W-1:0] sun_y;
  logic signed [nmmd_pkg::IN_W-1:0] sun_z;
  modport source (output valid, moon_x, moon_y, moon_z, sun_x, sun_y, sun_z,
                  input ready);
  modport sink (input valid, moon_x, moon_y, moon_z, sun_x, sun_y, sun_z,
                output ready);
endinterface

interface nmmd_out_if;
  logic                                valid;
  logic                                ready;
  logic [nmmd_pkg::MAG_W-1:0]          magnitude;
  logic signed [nmmd_pkg::PHASE_W-1:0] phase;
  logic                                new_minimum;
  logic                                search_done;
  logic [nmmd_pkg::MAG_W-1:0]          minimum_magnitude;
  logic [nmmd_pkg::IDX_W-1:0]          minimum_index;
  modport source (output valid, magnitude, phase, new_minimum, search_done,
                  minimum_magnitude, minimum_index, input ready);
  modport sink (input valid, magnitude, phase, new_minimum, search_done,
                minimum_magnitude, minimum_index, output ready);
endinterface

>>> rtl/core/nmmd_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
// Depends on nmmd_pkg (import only).
module nmmd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic [31:0] root,
  output logic        done
);
  import nmmd_pkg::*;

  logic [63:0] rem, r, b;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + b;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= n;
        r    <= '0;
        b    <= 64'd1 << 62;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r   <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b[1:0] != 2'b00) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/nmmd_div.sv
// Restoring divider, one quotient bit per cycle, quotient of FRAC_BITS+1 bits.
// Depends on nmmd_pkg (import only).
module nmmd_div #(
  parameter int FRAC_BITS = nmmd_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      num,
  input  logic [31:0]      den,
  output logic [FRAC_BITS:0] quo,
  output logic             done
);
  import nmmd_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [63:0]      rem, dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= {32'd0, den} << FRAC_BITS;
        quo  <= '0;
        cnt  <= CNT_W'(FRAC_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) rem <= rem - dsh;
        quo <= {quo[FRAC_BITS-1:0], fits};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/nmmd_cordic.sv
// Vectoring CORDIC arctangent, one micro-rotation per cycle, with
// pre-normalization and the zero-axis special cases. Depends on nmmd_pkg.
module nmmd_cordic #(
  parameter int SUM_W = nmmd_pkg::FRAC_BITS_DEF + 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SUM_W-1:0]             sx,
  input  logic signed [SUM_W-1:0]             sy,
  output logic signed [nmmd_pkg::PHASE_W-1:0] phase,
  output logic                                done
);
  import nmmd_pkg::*;

  cordic_state_t     state, state_next;
  logic signed [63:0] x, y;
  logic signed [31:0] z;
  logic [4:0]        i;
  logic              neg;
  logic [SUM_W-1:0]  ax, ay;
  logic [63:0]       xy_or;
  logic signed [63:0] xs, ys;
  logic signed [31:0] ang, zc;

  assign ax    = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign ay    = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  assign xy_or = x | y;
  assign xs    = x >>> i;
  assign ys    = y >>> i;
  assign ang   = cordic_angle(i);
  assign zc    = (z < 0) ? 32'sd0 :
                 (z > 32'(PHASE_HALF_PI)) ? 32'(PHASE_HALF_PI) : z;

  always_comb begin
    state_next = state;
    case (state)
      CD_IDLE: if (start && sy != '0 && sx != '0) state_next = CD_NORM;
      CD_NORM: if (xy_or >= (64'd1 << 60)) state_next = CD_ITER;
      CD_ITER: if (i == 5'(CORDIC_STEPS - 1)) state_next = CD_FIN;
      CD_FIN:  state_next = CD_IDLE;
      default: state_next = CD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= CD_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        CD_IDLE: if (start) begin
          if (sy == '0) begin
            phase <= '0;
            done  <= 1'b1;
          end else if (sx == '0) begin
            phase <= sy[SUM_W-1] ? -PHASE_HALF_PI : PHASE_HALF_PI;
            done  <= 1'b1;
          end
          x   <= 64'(ax);
          y   <= 64'(ay);
          z   <= '0;
          i   <= '0;
          neg <= sx[SUM_W-1] ^ sy[SUM_W-1];
        end
        CD_NORM: begin
          if (xy_or < (64'd1 << 52)) begin
            x <= x <<< 8;
            y <= y <<< 8;
          end else if (xy_or < (64'd1 << 60)) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end
        end
        CD_ITER: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end
          i <= i + 1'b1;
        end
        CD_FIN: begin
          phase <= neg ? PHASE_W'(-zc) : PHASE_W'(zc);
          done  <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/new_moon_minimum_detector.sv
// New-moon minimum detector top level: sequencer, shared multiplier,
// minimum tracking and result register. Depends on nmmd_pkg, nmmd_if,
// nmmd_sqrt, nmmd_div, nmmd_cordic.
//
//  channel  | dir | handshake      | beat contents
//  ---------+-----+----------------+-------------------------------------------
//  sample   | in  | valid / ready  | moon_x/y/z, sun_x/y/z (signed 32)
//  result   | out | valid / ready  | magnitude, phase, flags, minimum, index
//  cfg      | in  | cfg_write      | cfg_index selects register, cfg_data
//
// One sample at a time. Each nonzero vector is normalized by single-bit shifts
// (0..30 per vector); the bit-serial square root (run three times) and divider
// (run four times), both run fewer times when a vector is zero, and the
// arctangent, which may run past the magnitude root, set how long a sample takes.
// Reset (rst, synchronous) clears control, tracking state and config to
// defaults. A stalled result holds in the output register; the next sample
// is taken meanwhile and waits at the end of its work for the register.
module new_moon_minimum_detector #(
  parameter int FRAC_BITS   = nmmd_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = nmmd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [nmmd_pkg::CFG_W-1:0] cfg_data,
  nmmd_in_if.sink                    sample,
  nmmd_out_if.source                 result
);
  import nmmd_pkg::*;

  localparam int U_W   = FRAC_BITS + 2;   // signed unit component
  localparam int SUM_W = FRAC_BITS + 3;   // signed component sum
  localparam logic [MAG_W-1:0] MIN_NONE  = MAG_W'(64'd3 << FRAC_BITS);
  localparam logic [MAG_W-1:0] MAG_SAT   = MAG_W'(64'd1 << (FRAC_BITS + 1));
  localparam logic [CFG_W-1:0] RISE_RST  = CFG_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] NEAR_RST  =
    CFG_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  // configuration
  logic [WIN_W-1:0] window_samples;
  logic [CFG_W-1:0] rise_threshold, near_zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples      <= WINDOW_RESET;
      rise_threshold      <= RISE_RST;
      near_zero_threshold <= NEAR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WINDOW:    window_samples      <= cfg_data[WIN_W-1:0];
        CFG_RISE:      rise_threshold      <= cfg_data;
        CFG_NEAR_ZERO: near_zero_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  ctl_state_t state, state_next;

  logic signed [IN_W-1:0] vec [6];
  logic        vsel;
  logic [1:0]  cnt;
  logic [31:0] m [3];
  logic [2:0]  neg;
  logic [63:0] acc, prod;
  logic [31:0] r;
  logic signed [U_W-1:0]   um_x, um_y, us_x, us_y;
  logic signed [SUM_W-1:0] sx, sy;
  logic [MAG_W-1:0] mag;
  logic signed [PHASE_W-1:0] ph;
  logic        ph_ok;

  // tracking state
  logic [MAG_W-1:0]       previous_magnitude, running_minimum;
  logic                   have_previous;
  logic [COUNT_WIDTH-1:0] minimum_position, sample_counter;

  logic out_valid;
  logic out_free;

  logic [31:0] m_or;
  logic [31:0] mul_a;
  logic [SUM_W-1:0] ax_w, ay_w;
  logic [63:0] sum_n;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num;
  logic [FRAC_BITS:0] div_q;
  logic signed [U_W-1:0] u_new;
  logic        cordic_start, cordic_done;
  logic signed [PHASE_W-1:0] cordic_phase;

  assign m_or     = m[0] | m[1] | m[2];
  assign ax_w     = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign ay_w     = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  assign sum_n    = acc + prod;
  assign out_free = !out_valid || result.ready;

  always_comb begin
    case (state)
      ST_MSQ:  mul_a = (cnt == 2'd0) ? 32'(ax_w) : 32'(ay_w);
      default: mul_a = m[cnt];
    endcase
  end

  assign sqrt_start   = (state == ST_ACC && cnt == 2'd2) ||
                        (state == ST_MACC && cnt == 2'd1);
  assign div_start    = (state == ST_DIVGO);
  assign div_num      = ({32'd0, m[cnt]} << FRAC_BITS) + {33'd0, r[31:1]};
  assign cordic_start = (state == ST_MSQ) && (cnt == 2'd0);
  assign u_new        = neg[cnt] ? -U_W'(div_q) : U_W'(div_q);

  nmmd_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .n    (sum_n),
    .root (sqrt_root),
    .done (sqrt_done)
  );

  nmmd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (r),
    .quo  (div_q),
    .done (div_done)
  );

  nmmd_cordic #(.SUM_W(SUM_W)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .sx   (sx),
    .sy   (sy),
    .phase(cordic_phase),
    .done (cordic_done)
  );

  // minimum tracking, evaluated when the result is loaded
  logic                   rising, falling, new_min, done_early, done_count, done;
  logic [MAG_W-1:0]       min_upd;
  logic [COUNT_WIDTH-1:0] pos_upd, count_inc;

  always_comb begin
    rising     = !have_previous || (mag > previous_magnitude);
    falling    = have_previous && (mag < previous_magnitude);
    new_min    = falling && (mag < running_minimum);
    min_upd    = new_min ? mag : running_minimum;
    pos_upd    = new_min ? sample_counter : minimum_position;
    count_inc  = sample_counter + 1'b1;
    done_early = !new_min && (mag > rise_threshold) &&
                 (min_upd < near_zero_threshold) && rising;
    done_count = count_inc == COUNT_WIDTH'(window_samples);
    done       = done_early || done_count;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (sample.valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_NORM;
      ST_NORM: begin
        if (m_or == '0)                state_next = vsel ? ST_SUM : ST_LOAD;
        else if (m_or >= 32'h4000_0000) state_next = ST_SQ;
      end
      ST_SQ:    state_next = ST_ACC;
      ST_ACC:   state_next = (cnt == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT:  if (sqrt_done) state_next = ST_DIVGO;
      ST_DIVGO: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (cnt == 2'd0)   state_next = ST_DIVGO;
          else if (vsel)     state_next = ST_SUM;
          else               state_next = ST_LOAD;
        end
      end
      ST_SUM:   state_next = ST_MSQ;
      ST_MSQ:   state_next = ST_MACC;
      ST_MACC:  state_next = (cnt == 2'd1) ? ST_MSQRT : ST_MSQ;
      ST_MSQRT: if (sqrt_done) state_next = ST_PH;
      ST_PH:    if (ph_ok || cordic_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign sample.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample.valid) begin
      vec[0] <= sample.moon_x;
      vec[1] <= sample.moon_y;
      vec[2] <= sample.moon_z;
      vec[3] <= sample.sun_x;
      vec[4] <= sample.sun_y;
      vec[5] <= sample.sun_z;
      vsel   <= 1'b0;
    end
    prod <= 64'(mul_a) * 64'(mul_a);
    if (cordic_done) ph <= cordic_phase;
    case (state)
      ST_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          neg[k] <= vec[vsel ? k + 3 : k][IN_W-1];
          m[k]   <= vec[vsel ? k + 3 : k][IN_W-1] ? 32'(-vec[vsel ? k + 3 : k])
                                                  : 32'(vec[vsel ? k + 3 : k]);
        end
      end
      ST_NORM: begin
        if (m_or == '0) begin
          if (vsel) begin
            us_x <= '0;
            us_y <= '0;
          end else begin
            um_x <= '0;
            um_y <= '0;
          end
          vsel <= 1'b1;
        end else if (m_or < 32'h4000_0000) begin
          for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
        end else begin
          cnt <= 2'd0;
          acc <= '0;
        end
      end
      ST_ACC: begin
        acc <= sum_n;
        cnt <= cnt + 1'b1;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          r   <= sqrt_root;
          cnt <= 2'd0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          case ({vsel, cnt[0]})
            2'b00:   um_x <= u_new;
            2'b01:   um_y <= u_new;
            2'b10:   us_x <= u_new;
            default: us_y <= u_new;
          endcase
          cnt <= 2'd1;
          if (cnt == 2'd1) vsel <= 1'b1;
        end
      end
      ST_SUM: begin
        sx    <= SUM_W'(um_x) + SUM_W'(us_x);
        sy    <= SUM_W'(um_y) + SUM_W'(us_y);
        cnt   <= 2'd0;
        acc   <= '0;
        ph_ok <= 1'b0;
      end
      ST_MACC: begin
        acc <= sum_n;
        cnt <= cnt + 1'b1;
      end
      ST_MSQRT: begin
        if (cordic_done) ph_ok <= 1'b1;
        if (sqrt_done) mag <= (sqrt_root > MAG_SAT) ? MAG_SAT : sqrt_root;
      end
      ST_PH: if (cordic_done) ph_ok <= 1'b1;
      default: ;
    endcase
    if (state == ST_MSQ || state == ST_MACC) begin
      if (cordic_done) ph_ok <= 1'b1;
    end
  end

  // result register and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      previous_magnitude <= '0;
      have_previous      <= 1'b0;
      running_minimum    <= MIN_NONE;
      minimum_position   <= '0;
      sample_counter     <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid                <= 1'b1;
        result.magnitude         <= mag;
        result.phase             <= ph;
        result.new_minimum       <= new_min;
        result.search_done       <= done;
        result.minimum_magnitude <= min_upd;
        result.minimum_index     <= IDX_W'(pos_upd);
        if (done) begin
          previous_magnitude <= '0;
          have_previous      <= 1'b0;
          running_minimum    <= MIN_NONE;
          minimum_position   <= '0;
          sample_counter     <= '0;
        end else begin
          previous_magnitude <= mag;
          have_previous      <= 1'b1;
          running_minimum    <= min_upd;
          minimum_position   <= pos_upd;
          sample_counter     <= count_inc;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

endmodule

>>> tb/new_moon_minimum_detector_checker.sv
`timescale 1ns / 100ps
// Result checker for the new-moon minimum detector: predicts each result beat
// from the accepted sample beats and the register writes, and compares them.
// Depends on nmmd_pkg and nmmd_if.
module new_moon_minimum_detector_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  nmmd_in_if         sample,
  nmmd_out_if        result,
  output int         errors,
  output int         pending,
  output int         beats_seen,
  output int         windows_closed,
  output int         minima_seen
);
  import nmmd_pkg::*;

  typedef struct packed {
    logic [31:0]        magnitude;
    logic signed [30:0] phase;
    logic               new_minimum;
    logic               search_done;
    logic [31:0]        minimum_magnitude;
    logic [15:0]        minimum_index;
  } detect_t;

  localparam longint unsigned THREE_Q = 64'd3 << 30;
  localparam longint unsigned TWO_Q   = 64'd1 << 31;
  localparam longint HALF_PI = 64'sd843314857;

  detect_t expected_q[$];

  // register copies
  logic [15:0] win_len;
  logic [31:0] rise_thr;
  logic [31:0] near_thr;

  // tracking state
  longint unsigned prev_mag;
  bit              have_prev;
  longint unsigned run_min;
  logic [15:0]     min_pos;
  logic [15:0]     sample_cnt;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(input int i);
    case (i)
      0: return 421657428;
      1: return 248918915;
      2: return 131521918;
      3: return 66762579;
      4: return 33510843;
      5: return 16771758;
      6: return 8387925;
      7: return 4194219;
      8: return 2097141;
      9: return 1048575;
      10: return 524288;
      default: return 64'sd1 <<< (29 - i);
    endcase
  endfunction

  // unit vector, x and y components only; z only enters the length
  task automatic unit_xy(input logic signed [31:0] cx, cy, cz,
                         output longint ux, uy);
    longint unsigned mx, my, mz, mmax, len, qx, qy;
    mx = (cx < 0) ? longint'(-longint'(cx)) : longint'(cx);
    my = (cy < 0) ? longint'(-longint'(cy)) : longint'(cy);
    mz = (cz < 0) ? longint'(-longint'(cz)) : longint'(cz);
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
    if (mmax == 0) begin
      ux = 0;
      uy = 0;
    end else begin
      while (mmax < (64'd1 << 30)) begin
        mmax = mmax << 1;
        mx = mx << 1;
        my = my << 1;
        mz = mz << 1;
      end
      len = int_sqrt(mx * mx + my * my + mz * mz);
      qx = ((mx << 30) + len / 2) / len;
      qy = ((my << 30) + len / 2) / len;
      ux = (cx < 0) ? -longint'(qx) : longint'(qx);
      uy = (cy < 0) ? -longint'(qy) : longint'(qy);
    end
  endtask

  function automatic longint sum_angle(input longint sx, sy);
    longint unsigned a, b;
    longint x, y, z, xs;
    bit neg;
    if (sy == 0) return 0;
    if (sx == 0) return (sy > 0) ? HALF_PI : -HALF_PI;
    a = (sx < 0) ? -sx : sx;
    b = (sy < 0) ? -sy : sy;
    neg = (sx < 0) != (sy < 0);
    while ((a | b) < (64'd1 << 60)) begin
      a = a << 1;
      b = b << 1;
    end
    x = a;
    y = b;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      if (y > 0) begin
        x = x + (y >>> i);
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - (y >>> i);
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI) z = HALF_PI;
    return neg ? -z : z;
  endfunction

  task automatic clear_window();
    prev_mag   = 0;
    have_prev  = 0;
    run_min    = THREE_Q;
    min_pos    = '0;
    sample_cnt = '0;
  endtask

  task automatic predict_beat();
    longint mux, muy, sux, suy, sx, sy;
    longint unsigned ax, ay, mag;
    bit rising, falling, nmin, done;
    detect_t d;
    unit_xy(sample.moon_x, sample.moon_y, sample.moon_z, mux, muy);
    unit_xy(sample.sun_x, sample.sun_y, sample.sun_z, sux, suy);
    sx = mux + sux;
    sy = muy + suy;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    mag = int_sqrt(ax * ax + ay * ay);
    if (mag > TWO_Q) mag = TWO_Q;
    rising  = !have_prev || mag > prev_mag;
    falling = have_prev && mag < prev_mag;
    nmin    = falling && mag < run_min;
    if (nmin) begin
      run_min = mag;
      min_pos = sample_cnt;
    end
    done = !nmin && mag > rise_thr && run_min < near_thr && rising;
    if (16'(sample_cnt + 16'd1) == win_len) done = 1;
    d.magnitude         = mag[31:0];
    d.phase             = 31'(sum_angle(sx, sy));
    d.new_minimum       = nmin;
    d.search_done       = done;
    d.minimum_magnitude = run_min[31:0];
    d.minimum_index     = min_pos;
    expected_q.push_back(d);
    if (done) begin
      clear_window();
    end else begin
      sample_cnt = sample_cnt + 16'd1;
      prev_mag   = mag;
      have_prev  = 1;
    end
  endtask

  function automatic int field_diff(input string name, input longint unsigned exp_v,
                                    input longint unsigned act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: result %0d field %s mismatch: expected 0x%0h, got 0x%0h",
             $time, beats_seen, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    detect_t e;
    int bad;
    if (rst) begin
      win_len  <= WINDOW_RESET;
      rise_thr <= 32'd1 << 30;
      near_thr <= 32'd10737418;
      clear_window();
      expected_q.delete();
      errors <= 0;
      pending <= 0;
      beats_seen <= 0;
      windows_closed <= 0;
      minima_seen <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW:    win_len  <= cfg_data[15:0];
          CFG_RISE:      rise_thr <= cfg_data;
          CFG_NEAR_ZERO: near_thr <= cfg_data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) predict_beat();
      if (result.valid && result.ready) begin
        beats_seen <= beats_seen + 1;
        if (result.search_done) windows_closed <= windows_closed + 1;
        if (result.new_minimum) minima_seen <= minima_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          bad = field_diff("magnitude", e.magnitude, result.magnitude)
              + field_diff("phase", e.phase, result.phase)
              + field_diff("new_minimum", e.new_minimum, result.new_minimum)
              + field_diff("search_done", e.search_done, result.search_done)
              + field_diff("minimum_magnitude", e.minimum_magnitude,
                           result.minimum_magnitude)
              + field_diff("minimum_index", e.minimum_index, result.minimum_index);
          if (bad != 0) errors <= errors + 1;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

>>> tb/new_moon_minimum_detector_tb.sv
`timescale 1ns / 100ps
// Top of the new-moon minimum detector testbench: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on nmmd_pkg, nmmd_if, the detector RTL and the checker.
module new_moon_minimum_detector_tb;
  import nmmd_pkg::*;

  localparam real PI = 3.14159265358979;
  // margin allowed when draining, kept well above the work of one sample
  localparam int DRAIN_CYCLES = 500;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors, pending, beats_seen, windows_closed, minima_seen;
  int items_sent;
  bit calm;          // no gaps and no stalls while set
  int stall_left;

  nmmd_in_if  sample_ch ();
  nmmd_out_if result_ch ();

  new_moon_minimum_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch.sink),
    .result    (result_ch.source)
  );

  new_moon_minimum_detector_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample_ch),
    .result         (result_ch),
    .errors         (errors),
    .pending        (pending),
    .beats_seen     (beats_seen),
    .windows_closed (windows_closed),
    .minima_seen    (minima_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit: far above the time that all beats take, stalls included
  initial begin
    #20ms;
    $display("timeout: %0d results still expected", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // result back-pressure, re-rolled at a falling edge once the previous random hold has run out
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_ch.ready <= $urandom_range(0, 3) != 0;
      stall_left <= gap_len();
    end
  end

  // one sample beat; valid drops on the next falling edge after acceptance
  task automatic send_beat(input logic [31:0] mx, my, mz, sx, sy, sz);
    int g;
    g = calm ? 0 : gap_len();
    repeat (g) @(negedge clk);
    sample_ch.valid  = 1'b1;
    sample_ch.moon_x = mx;
    sample_ch.moon_y = my;
    sample_ch.moon_z = mz;
    sample_ch.sun_x  = sx;
    sample_ch.sun_y  = sy;
    sample_ch.sun_z  = sz;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    sample_ch.valid = 1'b0;
    items_sent++;
  endtask

  // registers only change with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] win, input logic [31:0] rise,
                          input logic [31:0] near);
    write_reg(CFG_WINDOW, {16'd0, win});
    write_reg(CFG_RISE, rise);
    write_reg(CFG_NEAR_ZERO, near);
  endtask

  task automatic send_noise(input int n);
    logic [31:0] v[6];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 5))
          0: v[k] = $urandom_range(0, 3) - 1;           // -1, 0, 1, 2
          1: v[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          2: v[k] = $urandom_range(0, 65535) - 32768;
          default: v[k] = $urandom;
        endcase
      end
      send_beat(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
  endtask

  // Moon swept through opposition to the Sun in the xy plane, so the
  // magnitude falls toward zero and rises again; content is random.
  task automatic send_sweep(input int n);
    real base, moon_a, step, span, ms, ss;
    int mz, sz;
    base = ($urandom_range(0, 62831) / 10000.0);
    span = ($urandom_range(5, 60) / 1000.0);
    step = 2.0 * span / n;
    ms = $urandom_range(1000, 2000000000);
    ss = $urandom_range(1000, 2000000000);
    mz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) - 1000 : 0;
    sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) - 1000 : 0;
    for (int i = 0; i < n; i++) begin
      moon_a = base + PI - span + step * i;
      send_beat($rtoi(ms * $cos(moon_a)), $rtoi(ms * $sin(moon_a)), mz,
                $rtoi(ss * $cos(base)), $rtoi(ss * $sin(base)), sz);
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    items_sent = 0;
    cfg_write = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.moon_x = '0;
    sample_ch.moon_y = '0;
    sample_ch.moon_z = '0;
    sample_ch.sun_x = '0;
    sample_ch.sun_y = '0;
    sample_ch.sun_z = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero vectors, extremes, axis sums, saturation
    calm = 1'b1;
    send_beat(0, 0, 0, 0, 0, 0);
    send_beat(0, 0, 0, 5, 7, 9);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0);   // sum at 2.0
    send_beat(1, 5, 0, -1, 5, 0);                          // x sum zero
    send_beat(1, -5, 0, -1, -5, 0);                        // x sum zero, y negative
    send_beat(3, 1, 0, 3, -1, 0);                          // y sum zero
    send_beat(1, 0, 0, -1, 0, 0);                          // both sums zero
    send_beat(0, 0, 1, 0, 0, -1);                          // z only
    send_beat(1, 1, 1, -1, -1, -1);
    send_beat(-7, 3, 32'h8000_0000, 2, -9, 32'h7FFF_FFFF);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, -1);
    calm = 1'b0;
    send_sweep(12);

    // every beat closes a window; thresholds at their extremes
    set_regs(16'd1, 32'd0, 32'h8000_0000);
    send_noise(20);
    send_sweep(10);

    // longest window, early end impossible
    set_regs(16'd65535, 32'h8000_0000, 32'd0);
    send_noise(30);
    send_sweep(20);

    // opposition sweeps with a low rise threshold: early ends
    set_regs(16'd60, 32'd21474836, 32'd10737418);
    for (int i = 0; i < 4; i++) send_sweep($urandom_range(15, 40));
    send_noise(10);

    // back to reset-like levels, short windows, calm stretch first
    calm = 1'b1;
    set_regs(16'd7, 32'd1 << 30, 32'd10737418);
    send_sweep(14);
    calm = 1'b0;
    send_noise(20);

    // random settings, mostly sweeps
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(2, 50), $urandom_range(0, 32'h3FFF_FFFF) >> 4,
               $urandom_range(0, 32'h03FF_FFFF));
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(2, 8));
        else send_sweep($urandom_range(10, 30));
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d samples under several register settings; %0d results checked",
             items_sent, beats_seen);
    $display("%0d windows closed, %0d new minima reported", windows_closed, minima_seen);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> new_moon_minimum_detector.f
rtl/core/nmmd_pkg.sv
rtl/core/nmmd_if.sv
rtl/core/nmmd_sqrt.sv
rtl/core/nmmd_div.sv
rtl/core/nmmd_cordic.sv
rtl/core/new_moon_minimum_detector.sv
tb/new_moon_minimum_detector_checker.sv
tb/new_moon_minimum_detector_tb.sv
